// ===== rtl/core/mrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrl_pkg
// Shared types and constants of the message rate limiter.
// ----------------------------------------------------------------------------
package mrl_pkg;

   localparam int SLOT_W     = 6;
   localparam int TIME_W     = 32;
   localparam int SECONDS_W  = 16;
   localparam int CSR_IDX_W  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SECONDS  = CSR_IDX_W'(1);

   localparam logic [SECONDS_W-1:0] WINDOW_SECONDS_RESET = SECONDS_W'(10);
   localparam logic [SECONDS_W-1:0] BLOCK_SECONDS_RESET  = SECONDS_W'(30);

   localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_CALC
   } state_type;

endpackage

// ===== rtl/core/mrl_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrl_channels
// Valid/ready channels for message events, results and register writes.
// ----------------------------------------------------------------------------
interface mrl_req_if;
   logic                          valid;
   logic                          ready;
   logic [mrl_pkg::SLOT_W-1:0]    client_slot;
   logic [mrl_pkg::TIME_W-1:0]    now_seconds;

   modport source (output valid, output client_slot, output now_seconds, input ready);
   modport sink   (input valid, input client_slot, input now_seconds, output ready);
endinterface

interface mrl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          spamming;
   logic [mrl_pkg::TIME_W-1:0]    blocked_until;

   modport source (output valid, output spamming, output blocked_until, input ready);
   modport sink   (input valid, input spamming, input blocked_until, output ready);
endinterface

interface mrl_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mrl_pkg::CSR_IDX_W-1:0] index;
   logic [mrl_pkg::SECONDS_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/message_rate_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_rate_limiter
// Per-client sliding-window rate limiter over a ring of recent message times.
// ----------------------------------------------------------------------------
// A result is presented from the result register once its event is transferred and its
// row is read and updated, or later while the previous result still waits there.
// A new event is not accepted until the last one is through, as required by the
// read-modify-write of the client's row in the single-port state memory (read, then compute and write).
// Reset: synchronous; per-row valid bits make every client row read as empty,
// and both registers return to their defaults at once, with no clearing pass.
module message_rate_limiter #(
   parameter int CLIENT_SLOTS = 64,
   parameter int WINDOW_COUNT = 5
) (
   input  logic            clock,
   input  logic            reset,
   mrl_req_if.sink         req_bus,
   mrl_rsp_if.source       rsp_bus,
   mrl_csr_if.sink         csr_bus
);

   localparam int TW      = mrl_pkg::TIME_W;
   localparam int ADDR_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
   localparam int POS_W   = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
   localparam int TIMES_W = WINDOW_COUNT * TW;
   localparam int ROW_W   = TIMES_W + POS_W + TW;
   localparam int WIDE_W  = ADDR_W + mrl_pkg::SLOT_W;

   mrl_pkg::state_type state_ff, state_in;

   logic [mrl_pkg::SECONDS_W-1:0] window_ff, block_ff;

   logic [ROW_W-1:0]        row_mem [CLIENT_SLOTS];
   logic [CLIENT_SLOTS-1:0] row_valid_ff;
   logic [ROW_W-1:0]        rd_data_ff;
   logic                    rd_valid_ff;

   logic [ADDR_W-1:0]       addr_ff;
   logic                    in_range_ff;
   logic [TW-1:0]           now_ff;

   logic                    rsp_valid_ff;
   logic                    spam_ff;
   logic [TW-1:0]           until_ff;

   logic [WIDE_W-1:0]       slot_wide;
   logic                    req_in_range;
   logic                    accept;
   logic                    finish;

   logic [TW-1:0]           times_cur [WINDOW_COUNT];
   logic [TW-1:0]           times_new [WINDOW_COUNT];
   logic [POS_W-1:0]        pos_raw, pos_cur, pos_next;
   logic [TW-1:0]           deadline_cur, deadline_new;
   logic [TW-1:0]           oldest;
   logic                    full;
   logic                    spam;
   logic [TW-1:0]           span;
   logic [TW:0]             until_sum;
   logic [ROW_W-1:0]        row_new;

   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= mrl_pkg::WINDOW_SECONDS_RESET;
         block_ff  <= mrl_pkg::BLOCK_SECONDS_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            mrl_pkg::CSR_WINDOW_SECONDS: window_ff <= csr_bus.data;
            mrl_pkg::CSR_BLOCK_SECONDS:  block_ff  <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign slot_wide    = WIDE_W'(req_bus.client_slot);
   assign req_in_range = slot_wide < WIDE_W'(CLIENT_SLOTS);
   assign accept       = req_bus.valid && req_bus.ready;
   assign finish       = (state_ff == mrl_pkg::ST_CALC) && (!rsp_valid_ff || rsp_bus.ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrl_pkg::ST_IDLE: if (accept) state_in = mrl_pkg::ST_CALC;
         mrl_pkg::ST_CALC: if (finish) state_in = mrl_pkg::ST_IDLE;
         default:          state_in = mrl_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      unique case (state_ff)
         mrl_pkg::ST_IDLE: req_bus.ready = 1'b1;
         mrl_pkg::ST_CALC: req_bus.ready = 1'b0;
         default:          req_bus.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Event capture and row read.
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff     <= slot_wide[ADDR_W-1:0];
         in_range_ff <= req_in_range;
         now_ff      <= req_bus.now_seconds;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= row_mem[slot_wide[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (accept) begin
         rd_valid_ff <= req_in_range && row_valid_ff[slot_wide[ADDR_W-1:0]];
      end
   end

   // Row update.
   always_comb begin
      for (int i = 0; i < WINDOW_COUNT; i++) begin
         times_cur[i] = rd_valid_ff ? rd_data_ff[i*TW +: TW] : '0;
      end
      pos_raw      = rd_valid_ff ? rd_data_ff[TIMES_W +: POS_W] : '0;
      deadline_cur = rd_valid_ff ? rd_data_ff[TIMES_W+POS_W +: TW] : '0;

      pos_cur  = ({1'b0, pos_raw} >= (POS_W+1)'(WINDOW_COUNT)) ? '0 : pos_raw;
      pos_next = (pos_cur == POS_W'(WINDOW_COUNT - 1)) ? '0 : pos_cur + POS_W'(1);

      full   = 1'b1;
      oldest = now_ff;
      for (int i = 0; i < WINDOW_COUNT; i++) begin
         times_new[i] = (pos_cur == POS_W'(i)) ? now_ff : times_cur[i];
         if (times_new[i] == '0) begin
            full = 1'b0;
         end
         if (times_new[i] < oldest) begin
            oldest = times_new[i];
         end
      end

      span      = now_ff - oldest;
      spam      = full && (span <= TW'(window_ff));
      until_sum = {1'b0, now_ff} + (TW+1)'(block_ff);
      if (!spam) begin
         deadline_new = deadline_cur;
      end else if (until_sum[TW]) begin
         deadline_new = mrl_pkg::MAX_TIME;
      end else begin
         deadline_new = until_sum[TW-1:0];
      end

      for (int i = 0; i < WINDOW_COUNT; i++) begin
         row_new[i*TW +: TW] = times_new[i];
      end
      row_new[TIMES_W +: POS_W]     = pos_next;
      row_new[TIMES_W+POS_W +: TW] = deadline_new;
   end

   always_ff @(posedge clock) begin
      if (finish && in_range_ff) begin
         row_mem[addr_ff] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (finish && in_range_ff) begin
         row_valid_ff[addr_ff] <= 1'b1;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         spam_ff  <= in_range_ff && spam;
         until_ff <= in_range_ff ? deadline_new : '0;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.spamming      = spam_ff;
   assign rsp_bus.blocked_until = until_ff;

endmodule
